// ===== sv/dma_pkg.sv =====
// Package for the decimal mantissa ALU: operation codes, widths and the
// transfer record passed from the front part to the back part.
// No dependencies.
package dma_pkg;

    localparam int MANT_W        = 96;
    localparam int LOW_W         = 64;
    localparam int HIGH_W        = 32;
    localparam int INT_W         = 32;
    localparam int SCALE_W       = 7;
    localparam int OP_W          = 3;
    localparam int CMP_W         = 2;
    localparam int DEF_QUEUE_DEPTH = 2;
    localparam int DEF_BITS_PER_STAGE = 4;

    localparam logic [INT_W-1:0] TEN = 32'd10;

    localparam logic [OP_W-1:0] OP_MUL10 = 3'd0;
    localparam logic [OP_W-1:0] OP_DIV10 = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM   = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP   = 3'd4;

    localparam logic [CMP_W-1:0] CMP_EQ = 2'd0;
    localparam logic [CMP_W-1:0] CMP_GT = 2'd1;
    localparam logic [CMP_W-1:0] CMP_LT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MANT_W-1:0]  a;
        logic               sign;
        logic [SCALE_W-1:0] scale;
        logic [INT_W-1:0]   divisor;
        logic [MANT_W-1:0]  mant;
        logic [CMP_W-1:0]   cmp;
        logic               ovf;
        logic               dz;
    } job_t;

endpackage

// ===== sv/dma_if.sv =====
// Channel interfaces of the decimal mantissa ALU: request and response.
// Depends on dma_pkg.
interface dma_req_if
    import dma_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     req_type;
    logic [LOW_W-1:0]    a_low;
    logic [HIGH_W-1:0]   a_high;
    logic                a_sign;
    logic [SCALE_W-1:0]  a_scale;
    logic [LOW_W-1:0]    b_low;
    logic [HIGH_W-1:0]   b_high;
    logic [INT_W-1:0]    operand_int;

    modport source (output valid, req_type, a_low, a_high, a_sign, a_scale,
                    b_low, b_high, operand_int, input ready);
    modport sink   (input valid, req_type, a_low, a_high, a_sign, a_scale,
                    b_low, b_high, operand_int, output ready);
endinterface

interface dma_rsp_if
    import dma_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LOW_W-1:0]    res_low;
    logic [HIGH_W-1:0]   res_high;
    logic                res_sign;
    logic [SCALE_W-1:0]  res_scale;
    logic [INT_W-1:0]    remainder;
    logic [CMP_W-1:0]    cmp_result;
    logic                overflow;
    logic                divide_by_zero;

    modport source (output valid, res_low, res_high, res_sign, res_scale, remainder,
                    cmp_result, overflow, divide_by_zero, input ready);
    modport sink   (input valid, res_low, res_high, res_sign, res_scale, remainder,
                    cmp_result, overflow, divide_by_zero, output ready);
endinterface

// ===== sv/dma_front.sv =====
// Front part: classifies a request and works out the combinational operations
// (multiply by ten, add, compare). Depends on dma_pkg.
module dma_front
    import dma_pkg::*;
(
    input  logic [OP_W-1:0]    req_type,
    input  logic [MANT_W-1:0]  a,
    input  logic [MANT_W-1:0]  b,
    input  logic               a_sign,
    input  logic [SCALE_W-1:0] a_scale,
    input  logic [INT_W-1:0]   operand_int,
    output job_t               job
);

    logic [MANT_W:0]   sum;
    logic [MANT_W-1:0] times_ten;

    assign sum       = {1'b0, a} + {{(MANT_W-INT_W+1){1'b0}}, operand_int};
    assign times_ten = (a << 3) + (a << 1);

    always_comb
    begin
        job         = '0;
        job.op      = req_type;
        job.a       = a;
        job.sign    = a_sign;
        job.scale   = a_scale;
        job.divisor = operand_int;
        job.mant    = a;
        case (req_type)
            OP_MUL10:
            begin
                job.mant = times_ten;
            end
            OP_DIV10:
            begin
                job.divisor = TEN;
            end
            OP_ADD:
            begin
                job.ovf = sum[MANT_W];
                if (!sum[MANT_W])
                begin
                    job.mant = sum[MANT_W-1:0];
                end
            end
            OP_REM:
            begin
                job.dz = (operand_int == '0);
            end
            OP_CMP:
            begin
                if (a > b)
                begin
                    job.cmp = CMP_GT;
                end
                else if (a < b)
                begin
                    job.cmp = CMP_LT;
                end
                else
                begin
                    job.cmp = CMP_EQ;
                end
            end
            default:
            begin
                job.mant = a;
            end
        endcase
    end

endmodule

// ===== sv/dma_queue.sv =====
// Short register queue between the front and back parts.
// Depends on dma_pkg.
module dma_queue
    import dma_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/dma_back.sv =====
// Back part: a pipelined restoring divider that serves divide by ten and
// remainder, then the output register. Depends on dma_pkg.
module dma_back
    import dma_pkg::*;
#(
    parameter int BITS_PER_STAGE = DEF_BITS_PER_STAGE
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  job_t in_job,
    output logic in_pop,
    dma_rsp_if.source rsp
);

    localparam int STAGES = MANT_W / BITS_PER_STAGE;

    typedef struct packed {
        job_t              job;
        logic [INT_W-1:0]  rem;
        logic [MANT_W-1:0] qd;
    } stage_t;

    stage_t              pipe_reg [STAGES];
    logic [STAGES-1:0]   valid_reg;
    logic                out_valid_reg;
    logic [MANT_W-1:0]   out_mant_reg;
    logic                out_sign_reg;
    logic [SCALE_W-1:0]  out_scale_reg;
    logic [INT_W-1:0]    out_rem_reg;
    logic [CMP_W-1:0]    out_cmp_reg;
    logic                out_ovf_reg;
    logic                out_dz_reg;
    logic                advance;
    stage_t              head;
    stage_t              last;

    // Each call runs BITS_PER_STAGE quotient steps; the dividend bits leave
    // at the top of qd while quotient bits enter at the bottom.
    function automatic stage_t div_step(input stage_t s);
        stage_t            r;
        logic [INT_W:0]    t;
        r = s;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            t    = {r.rem, r.qd[MANT_W-1]};
            r.qd = r.qd << 1;
            if (t >= {1'b0, r.job.divisor})
            begin
                t       = t - {1'b0, r.job.divisor};
                r.qd[0] = 1'b1;
            end
            r.rem = t[INT_W-1:0];
        end
        return r;
    endfunction

    assign advance = !out_valid_reg || rsp.ready;
    assign in_pop  = advance && in_valid;

    always_comb
    begin
        head.job = in_job;
        head.rem = '0;
        head.qd  = in_job.a;
    end

    assign last = pipe_reg[STAGES-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pipe_reg[0] <= div_step(head);
            for (int k = 1; k < STAGES; k++)
            begin
                pipe_reg[k] <= div_step(pipe_reg[k-1]);
            end
            out_mant_reg  <= (last.job.op == OP_DIV10) ? last.qd : last.job.mant;
            out_sign_reg  <= last.job.sign;
            out_scale_reg <= (last.job.op == OP_DIV10) ? '0 : last.job.scale;
            out_rem_reg   <= (last.job.op == OP_REM && !last.job.dz) ? last.rem : '0;
            out_cmp_reg   <= last.job.cmp;
            out_ovf_reg   <= last.job.ovf;
            out_dz_reg    <= last.job.dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[STAGES-2:0], in_valid};
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.res_low        = out_mant_reg[LOW_W-1:0];
    assign rsp.res_high       = out_mant_reg[MANT_W-1:LOW_W];
    assign rsp.res_sign       = out_sign_reg;
    assign rsp.res_scale      = out_scale_reg;
    assign rsp.remainder      = out_rem_reg;
    assign rsp.cmp_result     = out_cmp_reg;
    assign rsp.overflow       = out_ovf_reg;
    assign rsp.divide_by_zero = out_dz_reg;

endmodule

// ===== sv/decimal_mantissa_alu.sv =====
// Top level of the decimal mantissa ALU: front part, queue and divider back part.
// Depends on dma_pkg, dma_if, dma_front, dma_queue and dma_back.
//
//  channel | modport | carries
//  req     | sink    | req_type, a_low/a_high/a_sign/a_scale, b_low/b_high, operand_int
//  rsp     | source  | res_low/high/sign/scale, remainder, cmp_result, flags
//
// One transfer is taken per cycle while the queue has room. Every request runs
// through the queue, the divider pipeline of 96/BITS_PER_STAGE stages and the
// output register.
// Reset clears the queue pointers, count, pipeline and output valid bits only.
// A stalled response holds the whole pipeline; the queue absorbs requests meanwhile.
module decimal_mantissa_alu
    import dma_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
    parameter int BITS_PER_STAGE = DEF_BITS_PER_STAGE
)
(
    input logic clk,
    input logic rst_n,
    dma_req_if.sink   req,
    dma_rsp_if.source rsp
);

    job_t front_job;
    job_t head_job;
    logic full;
    logic not_empty;
    logic pop;

    assign req.ready = !full;

    dma_front u_front (
        .req_type    (req.req_type),
        .a           ({req.a_high, req.a_low}),
        .b           ({req.b_high, req.b_low}),
        .a_sign      (req.a_sign),
        .a_scale     (req.a_scale),
        .operand_int (req.operand_int),
        .job         (front_job)
    );

    dma_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req.valid && !full),
        .push_data (front_job),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (head_job)
    );

    dma_back #(.BITS_PER_STAGE(BITS_PER_STAGE)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (not_empty),
        .in_job   (head_job),
        .in_pop   (pop),
        .rsp      (rsp)
    );

endmodule

// ===== sv/dma_checker.sv =====
// Port-level checks for the decimal mantissa ALU and their bind to the top level.
// Depends on dma_pkg.
module dma_checker
    import dma_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [LOW_W-1:0]   res_low,
    input logic [INT_W-1:0]   remainder,
    input logic [CMP_W-1:0]   cmp_result,
    input logic               overflow,
    input logic               divide_by_zero
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_low))
        else $error("response dropped or changed while stalled");

    a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmp_result != 2'd3)
        else $error("compare code out of range");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(overflow && divide_by_zero) && !(overflow && cmp_result != CMP_EQ))
        else $error("flags of two operations set together");

    a_dz_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && divide_by_zero |-> remainder == '0 && cmp_result == CMP_EQ)
        else $error("remainder not zero on zero divisor");

endmodule

bind decimal_mantissa_alu dma_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .res_low        (rsp.res_low),
    .remainder      (rsp.remainder),
    .cmp_result     (rsp.cmp_result),
    .overflow       (rsp.overflow),
    .divide_by_zero (rsp.divide_by_zero)
);
